// ----- rtl/core/string_hash_engine_assert.svh -----
// Assertion macros used by the string hash engine RTL.
`ifndef STRING_HASH_ENGINE_ASSERT_SVH
`define STRING_HASH_ENGINE_ASSERT_SVH

// The condition on the left implies the one on the right in the same cycle.
`define SHE_ASSERT_SAME(lbl, cond, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
    else $error("assertion failed");

// The condition on the left implies the one on the right in the next cycle.
`define SHE_ASSERT_NEXT(lbl, cond, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
    else $error("assertion failed");

`endif

// ----- rtl/core/shash_pkg.sv -----
// Types, constants and start values for the string hash engine.
package shash_pkg;

  typedef enum logic [2:0] {
    MODE_BKDR = 3'd0,
    MODE_SDBM = 3'd1,
    MODE_RS   = 3'd2,
    MODE_JS   = 3'd3,
    MODE_ELF  = 3'd4,
    MODE_DJB  = 3'd5
  } mode_t;

  localparam logic [31:0] BKDR_SEED    = 32'd131;
  localparam logic [31:0] RS_STEP      = 32'd378551;
  localparam logic [31:0] RS_START     = 32'd63689;
  localparam logic [31:0] JS_START     = 32'd1315423911;
  localparam logic [31:0] DJB_START    = 32'd5381;
  localparam logic [31:0] ELF_TOP_MASK = 32'hF000_0000;

  // Starting hash of a mode; the unused codes start like BKDR.
  function automatic logic [31:0] start_value(input mode_t mode);
    logic [31:0] val;
    case (mode)
      MODE_JS:  val = JS_START;
      MODE_DJB: val = DJB_START;
      default:  val = 32'd0;
    endcase
    return val;
  endfunction

endpackage

// ----- rtl/core/string_hash_engine.sv -----
// Streaming string hash engine: six selectable 32-bit byte hashes.
// Takes one byte per cycle while in_stall is low; the recurrence register absorbs each byte at acceptance.
// A zero byte's result is valid in the output register the cycle after its acceptance.
// Throughput is one request per cycle while in_stall is low, set by the hash update loop.
// Synchronous active-low reset: BKDR mode, hash 0, RS multiplier 63689, output empty.
module string_hash_engine (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_char_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [30:0] out_hash_value
);

  shash_pkg::mode_t mode_r;
  logic [31:0] hash_r, hash_nxt;
  logic [31:0] rs_mult_r, rs_mult_nxt;
  logic        out_valid_r;
  logic [30:0] out_hash_r;

  logic        in_accept;
  logic        end_of_string;
  logic [31:0] char_ext;
  logic [31:0] rs_prod;
  logic [31:0] elf_sum;
  logic [31:0] elf_top;
  logic [31:0] upd_hash;

  assign in_stall      = out_valid_r && out_stall;
  assign in_accept     = in_valid && !in_stall;
  assign end_of_string = (in_char_byte == 8'd0);
  assign char_ext      = {24'd0, in_char_byte};
  assign rs_prod       = hash_r * rs_mult_r;
  assign elf_sum       = (hash_r << 4) + char_ext;
  assign elf_top       = elf_sum & shash_pkg::ELF_TOP_MASK;

  always_comb begin
    case (mode_r)
      shash_pkg::MODE_SDBM: upd_hash = char_ext + (hash_r << 6) + (hash_r << 16) - hash_r;
      shash_pkg::MODE_RS:   upd_hash = rs_prod + char_ext;
      shash_pkg::MODE_JS:   upd_hash = hash_r ^ ((hash_r << 5) + char_ext + (hash_r >> 2));
      // Folding the top nibble back in and clearing it is a no-op when it is zero.
      shash_pkg::MODE_ELF:  upd_hash = (elf_sum ^ (elf_top >> 24)) & ~elf_top;
      shash_pkg::MODE_DJB:  upd_hash = hash_r + (hash_r << 5) + char_ext;
      default:              upd_hash = hash_r * shash_pkg::BKDR_SEED + char_ext;
    endcase
  end

  always_comb begin
    hash_nxt    = hash_r;
    rs_mult_nxt = rs_mult_r;
    if (cfg_wr_en) begin
      hash_nxt    = shash_pkg::start_value(shash_pkg::mode_t'(cfg_wr_data));
      rs_mult_nxt = shash_pkg::RS_START;
    end else if (in_accept) begin
      if (end_of_string) begin
        hash_nxt    = shash_pkg::start_value(mode_r);
        rs_mult_nxt = shash_pkg::RS_START;
      end else begin
        hash_nxt = upd_hash;
        if (mode_r == shash_pkg::MODE_RS) begin
          rs_mult_nxt = rs_mult_r * shash_pkg::RS_STEP;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= shash_pkg::MODE_BKDR;
      hash_r      <= 32'd0;
      rs_mult_r   <= shash_pkg::RS_START;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        mode_r <= shash_pkg::mode_t'(cfg_wr_data);
      end
      hash_r    <= hash_nxt;
      rs_mult_r <= rs_mult_nxt;
      if (in_accept && end_of_string) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && end_of_string) begin
      out_hash_r <= hash_r[30:0];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_hash_value = out_hash_r;

`include "string_hash_engine_assert.svh"

  `SHE_ASSERT_SAME(a_stall_needs_full_output, in_stall, out_valid_r)
  `SHE_ASSERT_NEXT(a_terminator_gives_result, in_accept && end_of_string, out_valid_r)
  `SHE_ASSERT_NEXT(a_cfg_reloads_multiplier, cfg_wr_en, rs_mult_r == shash_pkg::RS_START)

endmodule

// ----- sim/string_hash_checker.sv -----
// Checker for the string hash engine: predicts each string hash and compares results.
module string_hash_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_wr_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_char_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [30:0] out_hash_value,
  output int          fail_count,
  output int          hashes_owed
);

  logic [2:0]  mode_q;
  logic [31:0] hash_acc;
  logic [31:0] rs_mult;
  logic [30:0] oldest_hash;
  logic [30:0] pending_hashes[$];

  initial begin
    fail_count = 0;
    hashes_owed = 0;
  end

  function automatic logic [31:0] seed_of(logic [2:0] mode);
    logic [31:0] seed;
    case (mode)
      shash_pkg::MODE_JS:  seed = shash_pkg::JS_START;
      shash_pkg::MODE_DJB: seed = shash_pkg::DJB_START;
      default:             seed = 32'd0;
    endcase
    return seed;
  endfunction

  // One step of the selected recurrence; the RS multiplier is advanced by the caller.
  function automatic logic [31:0] hash_byte(logic [2:0] mode, logic [31:0] h,
                                            logic [31:0] mult, logic [7:0] c);
    logic [31:0] cw;
    logic [31:0] nh;
    logic [31:0] top;
    cw = {24'd0, c};
    case (mode)
      shash_pkg::MODE_SDBM: nh = cw + (h << 6) + (h << 16) - h;
      shash_pkg::MODE_RS:   nh = h * mult + cw;
      shash_pkg::MODE_JS:   nh = h ^ ((h << 5) + cw + (h >> 2));
      shash_pkg::MODE_ELF: begin
        nh = (h << 4) + cw;
        top = nh & shash_pkg::ELF_TOP_MASK;
        if (top != 32'd0) begin
          nh = nh ^ (top >> 24);
          nh = nh & ~top;
        end
      end
      shash_pkg::MODE_DJB:  nh = h + (h << 5) + cw;
      default:              nh = h * shash_pkg::BKDR_SEED + cw;
    endcase
    return nh;
  endfunction

  task automatic report_mismatch(string what, logic [30:0] got, logic [30:0] want);
    $display("%0t: hash check: %s (got %h, want %h)", $time, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      mode_q = shash_pkg::MODE_BKDR;
      hash_acc = seed_of(shash_pkg::MODE_BKDR);
      rs_mult = shash_pkg::RS_START;
      pending_hashes.delete();
    end else begin
      // A result can never belong to a request taken at this same edge.
      if (out_valid && !out_stall) begin
        if (pending_hashes.size() == 0) begin
          report_mismatch("result with no string terminated", out_hash_value, '0);
        end else begin
          oldest_hash = pending_hashes.pop_front();
          if (out_hash_value !== oldest_hash)
            report_mismatch("hash_value differs", out_hash_value, oldest_hash);
        end
      end
      if (cfg_wr_en) begin
        mode_q = cfg_wr_data;
        hash_acc = seed_of(mode_q);
        rs_mult = shash_pkg::RS_START;
      end
      if (in_valid && !in_stall) begin
        if (in_char_byte != 8'd0) begin
          hash_acc = hash_byte(mode_q, hash_acc, rs_mult, in_char_byte);
          if (mode_q == shash_pkg::MODE_RS) rs_mult = rs_mult * shash_pkg::RS_STEP;
        end else begin
          pending_hashes.push_back(hash_acc[30:0]);
          hash_acc = seed_of(mode_q);
          rs_mult = shash_pkg::RS_START;
        end
      end
    end
    hashes_owed = pending_hashes.size();
  end

endmodule

// ----- sim/string_hash_engine_test.sv -----
// Testbench top for the string hash engine: clock, reset, stimulus and verdict.
module string_hash_engine_test;

  localparam logic [2:0] MODE_SPARE_LO = 3'd6;
  localparam logic [2:0] MODE_SPARE_HI = 3'd7;
  localparam int QUIET_LIMIT = 2000;
  localparam int BYTE_TARGET = 1100;

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [2:0]  cfg_wr_data;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_char_byte;
  logic        out_valid;
  logic        out_stall;
  logic [30:0] out_hash_value;

  int fail_count;
  int hashes_owed;
  int idle_pct = 36;
  int bytes_sent = 0;
  int quiet_cycles = 0;

  string_hash_engine DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_char_byte   (in_char_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_hash_value (out_hash_value)
  );

  string_hash_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_char_byte   (in_char_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_hash_value (out_hash_value),
    .fail_count     (fail_count),
    .hashes_owed    (hashes_owed)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_valid = 1'b0;
    in_char_byte = '0;
    out_stall = 1'b0;
  end

  always @(negedge clk) begin
    if (rst_n) out_stall = ($urandom_range(99) < idle_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || cfg_wr_en || (in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("** string_hash_engine: FAILED **");
      $finish;
    end
  end

  // Called at a falling edge; returns at the falling edge after the request is taken.
  task automatic send_byte(logic [7:0] b);
    while ($urandom_range(99) < idle_pct) begin
      in_valid = 1'b0;
      in_char_byte = 8'($urandom_range(255));
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_char_byte = b;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    @(negedge clk);
    bytes_sent++;
  endtask

  task automatic wait_drained();
    while (hashes_owed != 0) @(negedge clk);
  endtask

  task automatic write_mode(logic [2:0] mode);
    in_valid = 1'b0;
    wait_drained();
    // Let the last absorbed byte settle before the mode is changed.
    repeat (3) @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_wr_data = mode;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  task automatic send_string(int len);
    for (int i = 0; i < len; i++) send_byte(8'($urandom_range(1, 255)));
    send_byte(8'd0);
  endtask

  initial begin
    int pick;
    int len;
    logic [2:0] modes[8];
    modes = '{shash_pkg::MODE_BKDR, shash_pkg::MODE_SDBM, shash_pkg::MODE_RS,
              shash_pkg::MODE_JS, shash_pkg::MODE_ELF, shash_pkg::MODE_DJB,
              MODE_SPARE_LO, MODE_SPARE_HI};

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Empty string straight out of reset, then the byte extremes.
    send_byte(8'd0);
    send_byte(8'hFF);
    send_byte(8'h01);
    send_byte(8'd0);
    for (int m = 1; m <= 5; m++) begin
      write_mode(modes[m]);
      send_byte(8'hFF);
      send_byte(8'h80);
      send_byte(8'd0);
    end
    write_mode(MODE_SPARE_LO);
    send_byte(8'h01);
    send_byte(8'd0);
    write_mode(MODE_SPARE_HI);
    send_byte(8'h7F);
    send_byte(8'd0);
    // A mode change in the middle of a string drops the partial hash.
    send_byte(8'h7F);
    write_mode(shash_pkg::MODE_JS);
    send_byte(8'd0);

    while (bytes_sent < BYTE_TARGET) begin
      idle_pct = (bytes_sent >= 500 && bytes_sent < 700) ? 0 : 36;
      pick = $urandom_range(99);
      if (pick < 6) begin
        // Broken string: a few bytes, then a new mode.
        for (int i = $urandom_range(1, 6); i > 0; i--) send_byte(8'($urandom_range(1, 255)));
        write_mode(modes[$urandom_range(7)]);
      end else if (pick < 12) begin
        write_mode(modes[$urandom_range(7)]);
      end else if (pick < 14) begin
        in_valid = 1'b0;
        wait_drained();
      end else begin
        pick = $urandom_range(99);
        if (pick < 80) len = $urandom_range(0, 8);
        else if (pick < 95) len = $urandom_range(9, 24);
        else len = $urandom_range(25, 60);
        send_string(len);
      end
    end

    in_valid = 1'b0;
    idle_pct = 36;
    wait_drained();
    repeat (4) @(posedge clk);
    if (fail_count == 0)
      $display("** string_hash_engine: PASSED **");
    else
      $display("** string_hash_engine: FAILED **");
    $finish;
  end

endmodule
